// ===== sv/owjm_pkg.sv =====
// Shared types and constants for the omni-wheel joystick mixer.
`default_nettype none
package owjm_pkg;

  // Configuration register indexes.
  localparam logic REG_DB_LOW  = 1'b0;
  localparam logic REG_DB_HIGH = 1'b1;

  localparam logic [7:0] DB_LOW_RST  = 8'd116;
  localparam logic [7:0] DB_HIGH_RST = 8'd138;
  localparam logic [7:0] STICK_CENTER = 8'd127;

  // 0.70711 in Q16.
  localparam logic [15:0] DIAG_Q16 = 16'd46341;
  // floor(n/3) == (n*683) >> 11 for n below 2048.
  localparam logic [9:0] RECIP3 = 10'd683;
  localparam int RECIP3_SH = 11;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 16;
  localparam int ROOT_W    = 24;
  localparam int SQ_REM_W  = 26;
  localparam int QUO_W     = 24;
  localparam int DIV_REM_W = 25;

  // One classified stick sample: magnitudes and signs of x and y, mapped turn.
  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [7:0]        ax;
    logic [7:0]        ay;
    logic signed [7:0] w;
  } ctx_t;

endpackage
`default_nettype wire

// ===== sv/owjm_ifs.sv =====
// Valid/ready channel interfaces for joystick samples and wheel duties.
`default_nettype none
interface owjm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [7:0] turn;

  modport source (output valid, output stick_x, output stick_y, output turn, input ready);
  modport sink (input valid, input stick_x, input stick_y, input turn, output ready);
endinterface

interface owjm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_front_left;
  logic [7:0] duty_rear_left;
  logic [7:0] duty_rear_right;
  logic [7:0] duty_front_right;

  modport source (output valid, output duty_front_left, output duty_rear_left,
                  output duty_rear_right, output duty_front_right, input ready);
  modport sink (input valid, input duty_front_left, input duty_rear_left,
                input duty_rear_right, input duty_front_right, output ready);
endinterface
`default_nettype wire

// ===== sv/owjm_front.sv =====
// Front end: deadband registers, stick classification and turn mapping.
`default_nettype none
module owjm_front import owjm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_idx,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] stick_x,
  input  wire logic [7:0] stick_y,
  input  wire logic [7:0] turn,
  output logic            fq_valid,
  input  wire logic       fq_ready,
  output ctx_t            fq_item
);

  logic [7:0] db_low_r;
  logic [7:0] db_high_r;
  logic       fr_v_r;
  ctx_t       fr_ctx_r;
  ctx_t       ctx_nxt;
  logic       zx;
  logic       zy;
  logic [8:0] w9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_low_r  <= DB_LOW_RST;
      db_high_r <= DB_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DB_LOW:  db_low_r  <= cfg_wdata;
        REG_DB_HIGH: db_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    zx = (stick_x < db_high_r) && (stick_x > db_low_r);
    zy = (stick_y < db_high_r) && (stick_y > db_low_r);
    if (zx) begin
      ctx_nxt.sx = 1'b0;
      ctx_nxt.ax = 8'd0;
    end else if (stick_x >= STICK_CENTER) begin
      ctx_nxt.sx = 1'b0;
      ctx_nxt.ax = stick_x - STICK_CENTER;
    end else begin
      ctx_nxt.sx = 1'b1;
      ctx_nxt.ax = STICK_CENTER - stick_x;
    end
    // Vertical axis is inverted so that pushing up gives a positive y.
    if (zy) begin
      ctx_nxt.sy = 1'b0;
      ctx_nxt.ay = 8'd0;
    end else if (stick_y > STICK_CENTER) begin
      ctx_nxt.sy = 1'b1;
      ctx_nxt.ay = stick_y - STICK_CENTER;
    end else begin
      ctx_nxt.sy = 1'b0;
      ctx_nxt.ay = STICK_CENTER - stick_y;
    end
    // floor(t*254/255) equals t - 1 for every nonzero byte.
    w9 = {1'b0, turn} - {8'd0, (turn != 8'd0)} - {1'b0, STICK_CENTER};
    ctx_nxt.w = w9[7:0];
  end

  assign in_ready = !fr_v_r || fq_ready;
  assign fq_valid = fr_v_r;
  assign fq_item  = fr_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (in_ready) begin
      fr_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fr_ctx_r <= ctx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/owjm_fifo.sv =====
// Short queue that decouples the front end from the arithmetic pipeline.
`default_nettype none
module owjm_fifo import owjm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  ctx_t      push_item,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output ctx_t      pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  ctx_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule
`default_nettype wire

// ===== sv/owjm_back.sv =====
// Back end: vector length, speed, direction split and wheel mixing pipeline.
`default_nettype none
module owjm_back import owjm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic pop_valid,
  output logic      pop_ready,
  input  ctx_t      pop_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] duty_fl,
  output logic [7:0] duty_rl,
  output logic [7:0] duty_rr,
  output logic [7:0] duty_fr
);

  localparam int PRE_SH = 2 * FRAC_BITS - QUO_W;

  logic en;
  logic out_v_r;

  assign en        = !out_v_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_v_r;

  // Stage 0: squared length of the stick vector.
  logic           s0_v_r;
  ctx_t           s0_ctx_r;
  logic [Q_W-1:0] s0_q_r;
  logic [Q_W:0]   q_nxt;

  assign q_nxt = {9'd0, pop_item.ax} * {9'd0, pop_item.ax}
               + {9'd0, pop_item.ay} * {9'd0, pop_item.ay};

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= pop_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctx_r <= pop_item;
      s0_q_r   <= q_nxt[Q_W-1:0];
    end
  end

  // Square root of q * 2^32, one result bit per stage.
  logic                sq_v_r    [1:ROOT_W];
  ctx_t                sq_ctx_r  [1:ROOT_W];
  logic [Q_W-1:0]      sq_q_r    [1:ROOT_W];
  logic [ROOT_W-1:0]   sq_root_r [1:ROOT_W];
  logic [SQ_REM_W-1:0] sq_rem_r  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
    localparam int I = ROOT_W - 1 - k;
    logic                v_in;
    ctx_t                c_in;
    logic [Q_W-1:0]      q_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SQ_REM_W-1:0] rem_in;
    logic [1:0]          pair;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                take;

    if (k == 0) begin : g_first
      assign v_in    = s0_v_r;
      assign c_in    = s0_ctx_r;
      assign q_in    = s0_q_r;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = sq_v_r[k];
      assign c_in    = sq_ctx_r[k];
      assign q_in    = sq_q_r[k];
      assign root_in = sq_root_r[k];
      assign rem_in  = sq_rem_r[k];
    end

    if (I >= FRAC_BITS) begin : g_pair
      assign pair = q_in[2*(I-FRAC_BITS)+1 -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in[SQ_REM_W-3:0], pair};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctx_r[k+1]  <= c_in;
        sq_q_r[k+1]    <= q_in;
        sq_root_r[k+1] <= {root_in[ROOT_W-2:0], take};
        sq_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
      end
    end
  end

  // Speed = floor(2m/3), where m is the integer part of the root.
  logic              sp_v_r;
  ctx_t              sp_ctx_r;
  logic [ROOT_W-1:0] sp_r_r;
  logic [6:0]        sp_speed_r;
  logic [18:0]       sp_prod;

  assign sp_prod = {10'd0, sq_root_r[ROOT_W][ROOT_W-1:FRAC_BITS], 1'b0} * {9'd0, RECIP3};

  always_ff @(posedge clk) begin
    if (!rst_n) sp_v_r <= 1'b0;
    else if (en) sp_v_r <= sq_v_r[ROOT_W];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp_ctx_r   <= sq_ctx_r[ROOT_W];
      sp_r_r     <= sq_root_r[ROOT_W];
      sp_speed_r <= sp_prod[RECIP3_SH+6:RECIP3_SH];
    end
  end

  // Dividend numerators speed*|x| and speed*|y|.
  logic              nm_v_r;
  ctx_t              nm_ctx_r;
  logic [ROOT_W-1:0] nm_d_r;
  logic [14:0]       nm_x_r;
  logic [14:0]       nm_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nm_v_r <= 1'b0;
    else if (en) nm_v_r <= sp_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nm_ctx_r <= sp_ctx_r;
      nm_d_r   <= sp_r_r;
      nm_x_r   <= {8'd0, sp_speed_r} * {7'd0, sp_ctx_r.ax};
      nm_y_r   <= {8'd0, sp_speed_r} * {7'd0, sp_ctx_r.ay};
    end
  end

  // Restoring division of numerator * 2^32 by the Q16 length, one bit per stage.
  logic                 dv_v_r    [1:QUO_W];
  ctx_t                 dv_ctx_r  [1:QUO_W];
  logic [ROOT_W-1:0]    dv_d_r    [1:QUO_W];
  logic [DIV_REM_W-1:0] dvx_rem_r [1:QUO_W];
  logic [DIV_REM_W-1:0] dvy_rem_r [1:QUO_W];
  logic [QUO_W-1:0]     dvx_quo_r [1:QUO_W];
  logic [QUO_W-1:0]     dvy_quo_r [1:QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_dv
    logic                 v_in;
    ctx_t                 c_in;
    logic [ROOT_W-1:0]    d_in;
    logic [DIV_REM_W-1:0] rx_in;
    logic [DIV_REM_W-1:0] ry_in;
    logic [QUO_W-1:0]     qx_in;
    logic [QUO_W-1:0]     qy_in;
    logic [DIV_REM_W-1:0] rx_sh;
    logic [DIV_REM_W-1:0] ry_sh;
    logic [DIV_REM_W-1:0] dd;
    logic                 tx;
    logic                 ty;

    if (k == 0) begin : g_first
      assign v_in  = nm_v_r;
      assign c_in  = nm_ctx_r;
      assign d_in  = nm_d_r;
      assign rx_in = DIV_REM_W'({nm_x_r, {PRE_SH{1'b0}}});
      assign ry_in = DIV_REM_W'({nm_y_r, {PRE_SH{1'b0}}});
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = dv_v_r[k];
      assign c_in  = dv_ctx_r[k];
      assign d_in  = dv_d_r[k];
      assign rx_in = dvx_rem_r[k];
      assign ry_in = dvy_rem_r[k];
      assign qx_in = dvx_quo_r[k];
      assign qy_in = dvy_quo_r[k];
    end

    assign rx_sh = {rx_in[DIV_REM_W-2:0], 1'b0};
    assign ry_sh = {ry_in[DIV_REM_W-2:0], 1'b0};
    assign dd    = DIV_REM_W'(d_in);
    assign tx    = (rx_sh >= dd);
    assign ty    = (ry_sh >= dd);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ctx_r[k+1]  <= c_in;
        dv_d_r[k+1]    <= d_in;
        dvx_rem_r[k+1] <= tx ? rx_sh - dd : rx_sh;
        dvy_rem_r[k+1] <= ty ? ry_sh - dd : ry_sh;
        dvx_quo_r[k+1] <= {qx_in[QUO_W-2:0], tx};
        dvy_quo_r[k+1] <= {qy_in[QUO_W-2:0], ty};
      end
    end
  end

  // Diagonal mixes scaled by 0.70711, truncated toward zero.
  logic              mx_v_r;
  logic              mx_zero_r;
  logic signed [7:0] mx_w_r;
  logic [24:0]       mx_pm_r  [4];
  logic              mx_neg_r [4];
  logic [QUO_W-1:0]  vx_m;
  logic [QUO_W-1:0]  vy_m;
  logic signed [25:0] vxs;
  logic signed [25:0] vys;
  logic signed [25:0] mix  [4];
  logic [24:0]        smag [4];
  logic [40:0]        sprod[4];
  ctx_t               dc;

  always_comb begin
    dc   = dv_ctx_r[QUO_W];
    // A zero component has a zero quotient, which also covers a zero length.
    vx_m = (dc.ax == 8'd0) ? '0 : dvx_quo_r[QUO_W];
    vy_m = (dc.ay == 8'd0) ? '0 : dvy_quo_r[QUO_W];
    vxs  = dc.sx ? -$signed({2'b00, vx_m}) : $signed({2'b00, vx_m});
    vys  = dc.sy ? -$signed({2'b00, vy_m}) : $signed({2'b00, vy_m});
    mix[0] = vys - vxs;
    mix[1] = -vxs - vys;
    mix[2] = vxs - vys;
    mix[3] = vxs + vys;
    for (int j = 0; j < 4; j++) begin
      smag[j]  = mix[j][25] ? 25'(-mix[j]) : mix[j][24:0];
      sprod[j] = {16'd0, smag[j]} * {25'd0, DIAG_Q16};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mx_v_r <= 1'b0;
    else if (en) mx_v_r <= dv_v_r[QUO_W];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx_zero_r <= (dc.ax == 8'd0) && (dc.ay == 8'd0);
      mx_w_r    <= dc.w;
      for (int j = 0; j < 4; j++) begin
        mx_pm_r[j]  <= sprod[j][40:FRAC_BITS];
        mx_neg_r[j] <= mix[j][25];
      end
    end
  end

  // Add the turn term, take the magnitude, drop the fraction and saturate at 255.
  logic signed [26:0] wq;
  logic signed [26:0] ps   [4];
  logic signed [26:0] tsum [4];
  logic [26:0]        tmag [4];
  logic [7:0]         dsat [4];
  logic [7:0]         duty_r [4];

  always_comb begin
    wq = $signed({{3{mx_w_r[7]}}, mx_w_r, {FRAC_BITS{1'b0}}});
    for (int j = 0; j < 4; j++) begin
      ps[j]   = mx_neg_r[j] ? -$signed({2'b00, mx_pm_r[j]}) : $signed({2'b00, mx_pm_r[j]});
      tsum[j] = ps[j] + wq;
      tmag[j] = tsum[j][26] ? 27'(-tsum[j]) : tsum[j];
      dsat[j] = (tmag[j][26:FRAC_BITS] > 11'd255) ? 8'd255 : tmag[j][FRAC_BITS+7:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= mx_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        duty_r[j] <= dsat[j];
      end
    end
  end

  assign duty_fl = duty_r[0];
  assign duty_rl = duty_r[1];
  assign duty_rr = duty_r[2];
  assign duty_fr = duty_r[3];

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (duty_fl <= 8'd247 && duty_rl <= 8'd247 &&
                 duty_rr <= 8'd247 && duty_fr <= 8'd247))
    else $error("wheel duty beyond its bound");
  a_speed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_v_r |-> (sp_speed_r <= 7'd120)) else $error("speed beyond 120");
  a_centered: assert property (@(posedge clk) disable iff (!rst_n)
    (en && mx_v_r && mx_zero_r) |=>
      (duty_fl == duty_rl && duty_rl == duty_rr && duty_rr == duty_fr))
    else $error("centered stick gave unequal wheel duties");

endmodule
`default_nettype wire

// ===== sv/omni_wheel_joystick_mixer.sv =====
// Throughput: one sample per cycle while the output is not stalled; the root and
// the two divisions are bit-per-stage pipelines that take a new operand each cycle.
// A stalled output holds the whole back pipeline; the front and queue keep
// accepting until the queue fills.
// Reset (synchronous, active low) empties the pipeline and queue and sets the
// deadband to 116 and 138.
`default_nettype none
module omni_wheel_joystick_mixer import owjm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_idx,
  input  wire logic [7:0] cfg_wdata,
  owjm_in_if.sink         in_ch,
  owjm_out_if.source      out_ch
);

  logic fq_valid;
  logic fq_ready;
  ctx_t fq_item;
  logic bq_valid;
  logic bq_ready;
  ctx_t bq_item;

  owjm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .stick_x   (in_ch.stick_x),
    .stick_y   (in_ch.stick_y),
    .turn      (in_ch.turn),
    .fq_valid  (fq_valid),
    .fq_ready  (fq_ready),
    .fq_item   (fq_item)
  );

  owjm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  owjm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (bq_valid),
    .pop_ready (bq_ready),
    .pop_item  (bq_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .duty_fl   (out_ch.duty_front_left),
    .duty_rl   (out_ch.duty_rear_left),
    .duty_rr   (out_ch.duty_rear_right),
    .duty_fr   (out_ch.duty_front_right)
  );

endmodule
`default_nettype wire

// ===== tb/omni_wheel_joystick_mixer_test.sv =====
// Self-checking testbench for the omni-wheel joystick mixer.
`timescale 1ns / 100ps
`default_nettype none
module omni_wheel_joystick_mixer_test;
  import owjm_pkg::*;

  typedef struct packed {
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] turn;
  } sample_t;

  typedef struct packed {
    logic [7:0] fl;
    logic [7:0] rl;
    logic [7:0] rr;
    logic [7:0] fr;
  } duties_t;

  localparam int LATENCY = 55;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = REG_DB_LOW;
  logic [7:0] cfg_wdata = '0;

  owjm_in_if in_ch ();
  owjm_out_if out_ch ();

  omni_wheel_joystick_mixer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  sample_t pending_samples[$];
  duties_t expected_duties[$];
  logic [7:0] db_low = DB_LOW_RST;
  logic [7:0] db_high = DB_HIGH_RST;
  int error_count = 0;
  longint cycle_count = 0;
  int hold_off = 0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint centered(logic [7:0] b, bit invert);
    if (b < db_high && b > db_low) return 0;
    return invert ? 127 - longint'(b) : longint'(b) - 127;
  endfunction

  function automatic longint velocity_q16(longint unsigned speed, longint c,
                                          longint unsigned r);
    longint unsigned a;
    longint unsigned mc;
    if (r == 0) return 0;
    mc = (c < 0) ? -c : c;
    a = ((speed * mc) << 32) / r;
    return (c < 0) ? -longint'(a) : longint'(a);
  endfunction

  function automatic logic [7:0] wheel_duty(longint s, longint w);
    longint unsigned pm;
    longint p;
    longint t;
    longint unsigned d;
    pm = (((s < 0) ? -s : s) * 46341) >> 16;
    p = (s < 0) ? -longint'(pm) : longint'(pm);
    t = p + w * 65536;
    d = ((t < 0) ? -t : t) >> 16;
    return (d > 255) ? 8'd255 : d[7:0];
  endfunction

  function automatic duties_t mix_wheels(sample_t smp);
    longint x, y, w, vx, vy;
    longint unsigned q, speed, r;
    duties_t d;
    x = centered(smp.sx, 1'b0);
    y = centered(smp.sy, 1'b1);
    w = (longint'(smp.turn) * 254) / 255 - 127;
    q = x * x + y * y;
    speed = (int_sqrt(q) * 100) / 150;
    r = int_sqrt(q << 32);
    vx = velocity_q16(speed, x, r);
    vy = velocity_q16(speed, y, r);
    d.fl = wheel_duty(-vx + vy, w);
    d.rl = wheel_duty(-vx - vy, w);
    d.rr = wheel_duty(vx - vy, w);
    d.fr = wheel_duty(vx + vy, w);
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_duties.push_back(mix_wheels(pending_samples.pop_front()));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (pending_samples.size() != 0 && gap_left == 0) begin
        in_ch.valid <= 1'b1;
        in_ch.stick_x <= pending_samples[0].sx;
        in_ch.stick_y <= pending_samples[0].sy;
        in_ch.turn <= pending_samples[0].turn;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver stall pattern, plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ch.ready <= 1'b0;
    end else if (cycle_count % 1000 == 300) begin
      hold_off = 150;
      out_ch.ready <= 1'b0;
    end else if ((cycle_count / 300) % 3 == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    duties_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_duties.size() == 0) begin
        $display("unexpected transfer at cycle %0d", cycle_count);
        error_count++;
      end else begin
        want = expected_duties.pop_front();
        if (out_ch.duty_front_left !== want.fl)
          report_mismatch("front_left", out_ch.duty_front_left, want.fl);
        if (out_ch.duty_rear_left !== want.rl)
          report_mismatch("rear_left", out_ch.duty_rear_left, want.rl);
        if (out_ch.duty_rear_right !== want.rr)
          report_mismatch("rear_right", out_ch.duty_rear_right, want.rr);
        if (out_ch.duty_front_right !== want.fr)
          report_mismatch("front_right", out_ch.duty_front_right, want.fr);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("omni_wheel_joystick_mixer_test: errors");
      $finish;
    end
  end

  task automatic queue_sample(int sx, int sy, int turn);
    sample_t s;
    s.sx = 8'(sx);
    s.sy = 8'(sy);
    s.turn = 8'(turn);
    pending_samples.push_back(s);
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_ch.valid && expected_duties.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 8'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DB_LOW) db_low = 8'(value);
    else db_high = 8'(value);
  endtask

  task automatic random_phase(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 3);
      if (kind == 0)
        queue_sample($urandom_range(db_low, db_high), $urandom_range(db_low, db_high),
                     $urandom_range(0, 255));
      else
        queue_sample($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stick_x = '0;
    in_ch.stick_y = '0;
    in_ch.turn = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Corners, center, deadband edges and turn extremes under the reset deadband.
    queue_sample(127, 127, 127);
    queue_sample(127, 127, 0);
    queue_sample(127, 127, 255);
    queue_sample(0, 0, 128);
    queue_sample(255, 255, 128);
    queue_sample(0, 255, 0);
    queue_sample(255, 0, 255);
    queue_sample(116, 138, 127);
    queue_sample(117, 137, 127);
    queue_sample(138, 116, 200);
    queue_sample(255, 127, 255);
    queue_sample(127, 0, 0);
    queue_sample(170, 85, 64);
    queue_sample(85, 170, 191);
    queue_sample(0, 127, 1);
    queue_sample(128, 128, 254);
    drain();
    random_phase(200);

    // Inverted deadband: nothing counts as centered.
    write_reg(REG_DB_LOW, 255);
    write_reg(REG_DB_HIGH, 0);
    queue_sample(127, 127, 127);
    queue_sample(0, 255, 255);
    random_phase(150);

    // Widest deadband: almost every byte centered.
    write_reg(REG_DB_LOW, 0);
    write_reg(REG_DB_HIGH, 255);
    queue_sample(0, 255, 0);
    queue_sample(1, 254, 255);
    random_phase(150);

    write_reg(REG_DB_LOW, $urandom_range(0, 127));
    write_reg(REG_DB_HIGH, $urandom_range(128, 255));
    random_phase(230);

    if (error_count == 0) begin
      $display("omni_wheel_joystick_mixer_test: clean");
    end else begin
      $display("omni_wheel_joystick_mixer_test: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
